[rtl/core/cae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types, operation codes, microprograms and sine table for the
// chaotic attractor Euler step engine.
// ----------------------------------------------------------------------------
package cae_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 40;
    localparam int RF_DEPTH = 8;
    localparam int RF_AW  = 3;

    // Operation codes of the microprogram.
    localparam logic [4:0] OP_END  = 5'd0;
    localparam logic [4:0] OP_MUL  = 5'd1;
    localparam logic [4:0] OP_MACC = 5'd2;
    localparam logic [4:0] OP_MSUB = 5'd3;
    localparam logic [4:0] OP_PHS  = 5'd4;
    localparam logic [4:0] OP_FRC  = 5'd5;
    localparam logic [4:0] OP_AROM = 5'd6;
    localparam logic [4:0] OP_ROMD = 5'd7;
    localparam logic [4:0] OP_LDA  = 5'd8;
    localparam logic [4:0] OP_ADDA = 5'd9;
    localparam logic [4:0] OP_SUBA = 5'd10;
    localparam logic [4:0] OP_SAT  = 5'd11;
    localparam logic [4:0] OP_SATO = 5'd12;
    localparam logic [4:0] OP_CLMP = 5'd13;
    localparam logic [4:0] OP_LDIN = 5'd14;

    // Register file slots.
    localparam logic [2:0] R_X  = 3'd0;
    localparam logic [2:0] R_Y  = 3'd1;
    localparam logic [2:0] R_Z  = 3'd2;
    localparam logic [2:0] R_DX = 3'd3;
    localparam logic [2:0] R_DY = 3'd4;
    localparam logic [2:0] R_DZ = 3'd5;
    localparam logic [2:0] R_T0 = 3'd6;
    localparam logic [2:0] R_T1 = 3'd7;

    // System selector codes.
    localparam logic [3:0] SYS_LORENZ   = 4'd1;
    localparam logic [3:0] SYS_HALVOR   = 4'd2;
    localparam logic [3:0] SYS_AIZAWA   = 4'd3;
    localparam logic [3:0] SYS_FOURWING = 4'd4;
    localparam logic [3:0] SYS_DADRAS   = 4'd5;
    localparam logic [3:0] SYS_ZHOU     = 4'd6;
    localparam logic [3:0] SYS_THOMAS   = 4'd7;
    localparam logic [3:0] SYS_RAYLEIGH = 4'd8;
    localparam logic [3:0] SYS_CELL     = 4'd9;
    localparam logic [3:0] SYS_BOUALI   = 4'd10;
    localparam logic [3:0] SYS_CHENLEE  = 4'd11;
    localparam logic [3:0] SYS_ROESSLER = 4'd12;

    localparam logic signed [31:0] ONE        = 32'sd16777216;
    localparam logic signed [31:0] TURN_SCALE = 32'sd2670177;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ONE30  = 64'd1073741824;

    typedef struct packed {
        logic [4:0]         op;
        logic [2:0]         dst;
        logic [2:0]         sa;
        logic [2:0]         sb;
        logic               bk;
        logic signed [31:0] k;
    } t_instr;

    typedef struct packed {
        logic   issue;
        t_instr instr;
    } t_cmd;

    typedef logic [64:0][24:0] t_qrom;

    function automatic t_qrom f_build_qrom();
        t_qrom q;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        q = '0;
        for (int r = 0; r < 65; r++) begin
            a  = (PI_Q30 * 64'(r)) >> 7;
            a2 = (a * a) >> 30;
            t  = ONE30;
            t  = ONE30 - (((a2 * t) >> 30) / 64'd156);
            t  = ONE30 - (((a2 * t) >> 30) / 64'd110);
            t  = ONE30 - (((a2 * t) >> 30) / 64'd72);
            t  = ONE30 - (((a2 * t) >> 30) / 64'd42);
            t  = ONE30 - (((a2 * t) >> 30) / 64'd20);
            t  = ONE30 - (((a2 * t) >> 30) / 64'd6);
            s  = (((a * t) >> 30) + 64'd32) >> 6;
            if (s > 64'd16777216) begin
                s = 64'd16777216;
            end
            q[r] = s[24:0];
        end
        return q;
    endfunction

    localparam t_qrom C_QROM = f_build_qrom();

    // Full-wave sine table built from the quarter wave by symmetry.
    function automatic logic signed [31:0] f_sine_rom(input logic [7:0] k);
        logic [24:0] v;
        logic [6:0]  ri;
        ri = k[6] ? (7'd64 - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
        v  = C_QROM[ri];
        return k[7] ? -$signed({7'b0, v}) : $signed({7'b0, v});
    endfunction

    function automatic logic signed [31:0] f_sat40(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_instr f_i(input logic [4:0] op, input logic [2:0] dst,
                                   input logic [2:0] sa, input logic [2:0] sb,
                                   input logic bk, input logic signed [31:0] k);
        t_instr r;
        r.op = op; r.dst = dst; r.sa = sa; r.sb = sb; r.bk = bk; r.k = k;
        return r;
    endfunction

    function automatic t_instr f_mulr(input logic [2:0] d, a, b);
        return f_i(OP_MUL, d, a, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_mulk(input logic [2:0] d, a, input logic signed [31:0] k);
        return f_i(OP_MUL, d, a, R_X, 1'b1, k);
    endfunction
    function automatic t_instr f_maccr(input logic [2:0] a, b);
        return f_i(OP_MACC, R_X, a, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_macck(input logic [2:0] a, input logic signed [31:0] k);
        return f_i(OP_MACC, R_X, a, R_X, 1'b1, k);
    endfunction
    function automatic t_instr f_msubr(input logic [2:0] a, b);
        return f_i(OP_MSUB, R_X, a, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_msubk(input logic [2:0] a, input logic signed [31:0] k);
        return f_i(OP_MSUB, R_X, a, R_X, 1'b1, k);
    endfunction
    function automatic t_instr f_ldr(input logic [2:0] b);
        return f_i(OP_LDA, R_X, R_X, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_ldk(input logic signed [31:0] k);
        return f_i(OP_LDA, R_X, R_X, R_X, 1'b1, k);
    endfunction
    function automatic t_instr f_addr(input logic [2:0] b);
        return f_i(OP_ADDA, R_X, R_X, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_subr(input logic [2:0] b);
        return f_i(OP_SUBA, R_X, R_X, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_subk(input logic signed [31:0] k);
        return f_i(OP_SUBA, R_X, R_X, R_X, 1'b1, k);
    endfunction
    function automatic t_instr f_sat(input logic [2:0] d);
        return f_i(OP_SAT, d, R_X, R_X, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_sato(input logic [2:0] d);
        return f_i(OP_SATO, d, R_X, R_X, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_clmp(input logic [2:0] d, a);
        return f_i(OP_CLMP, d, a, R_X, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_phs(input logic [2:0] d, a);
        return f_i(OP_PHS, d, a, R_X, 1'b1, TURN_SCALE);
    endfunction
    function automatic t_instr f_frc(input logic [2:0] a, b);
        return f_i(OP_FRC, R_X, a, b, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_arom(input logic [2:0] a);
        return f_i(OP_AROM, R_X, a, R_X, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_romd(input logic [2:0] d, a);
        return f_i(OP_ROMD, d, a, R_X, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_ldin(input logic [2:0] d);
        return f_i(OP_LDIN, d, d, R_X, 1'b0, 32'sd0);
    endfunction
    function automatic t_instr f_end();
        return f_i(OP_END, R_X, R_X, R_X, 1'b0, 32'sd0);
    endfunction

    // Loads the three coordinates into the register file.
    function automatic t_instr f_head(input logic [5:0] pc);
        case (pc)
            6'd0:    return f_ldin(R_X);
            6'd1:    return f_ldin(R_Y);
            6'd2:    return f_ldin(R_Z);
            default: return f_end();
        endcase
    endfunction

    function automatic logic signed [31:0] f_dt(input logic [3:0] sys);
        case (sys)
            SYS_HALVOR:   return 32'sd83886;
            SYS_AIZAWA:   return 32'sd167772;
            SYS_FOURWING: return 32'sd83886;
            SYS_DADRAS:   return 32'sd167772;
            SYS_ZHOU:     return 32'sd33554;
            SYS_THOMAS:   return 32'sd1677722;
            SYS_RAYLEIGH: return 32'sd838861;
            SYS_CELL:     return 32'sd117441;
            SYS_BOUALI:   return 32'sd100663;
            SYS_CHENLEE:  return 32'sd67109;
            SYS_ROESSLER: return 32'sd838861;
            default:      return 32'sd167772;
        endcase
    endfunction

    // Euler update p' = sat(p + mul(dt, d)) for each coordinate.
    function automatic t_instr f_tail(input logic [3:0] sys, input logic [5:0] pc);
        logic signed [31:0] dt;
        dt = f_dt(sys);
        case (pc)
            6'd0:    return f_mulk(R_T0, R_DX, dt);
            6'd1:    return f_ldr(R_X);
            6'd2:    return f_addr(R_T0);
            6'd3:    return f_sato(R_X);
            6'd4:    return f_mulk(R_T0, R_DY, dt);
            6'd5:    return f_ldr(R_Y);
            6'd6:    return f_addr(R_T0);
            6'd7:    return f_sato(R_Y);
            6'd8:    return f_mulk(R_T0, R_DZ, dt);
            6'd9:    return f_ldr(R_Z);
            6'd10:   return f_addr(R_T0);
            6'd11:   return f_sato(R_Z);
            default: return f_end();
        endcase
    endfunction

    // Thomas term: -b*p + sine(v), into d.
    function automatic t_instr f_thomas(input logic [2:0] pc, input logic [2:0] p,
                                        input logic [2:0] v, input logic [2:0] d);
        case (pc)
            3'd0:    return f_phs(R_T0, v);
            3'd1:    return f_romd(R_T1, R_T0);
            3'd2:    return f_ldk(32'sd0);
            3'd3:    return f_msubk(p, 32'sd3187671);
            3'd4:    return f_arom(R_T0);
            3'd5:    return f_frc(R_T1, R_T0);
            default: return f_sat(d);
        endcase
    endfunction

    // Derivative programs, one per system; each leaves dx, dy, dz in DX, DY, DZ.
    function automatic t_instr f_prog(input logic [3:0] sys, input logic [5:0] pc);
        t_instr r;
        r = f_end();
        case (sys)
            SYS_HALVOR: begin
                case (pc)
                    6'd0:  r = f_ldk(32'sd0);
                    6'd1:  r = f_msubk(R_X, 32'sd23488102);
                    6'd2:  r = f_msubk(R_Y, 32'sd67108864);
                    6'd3:  r = f_msubk(R_Z, 32'sd67108864);
                    6'd4:  r = f_msubr(R_Y, R_Y);
                    6'd5:  r = f_sat(R_DX);
                    6'd6:  r = f_ldk(32'sd0);
                    6'd7:  r = f_msubk(R_Y, 32'sd23488102);
                    6'd8:  r = f_msubk(R_Z, 32'sd67108864);
                    6'd9:  r = f_msubk(R_X, 32'sd67108864);
                    6'd10: r = f_msubr(R_Z, R_Z);
                    6'd11: r = f_sat(R_DY);
                    6'd12: r = f_ldk(32'sd0);
                    6'd13: r = f_msubk(R_Z, 32'sd23488102);
                    6'd14: r = f_msubk(R_X, 32'sd67108864);
                    6'd15: r = f_msubk(R_Y, 32'sd67108864);
                    6'd16: r = f_msubr(R_X, R_X);
                    6'd17: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_AIZAWA: begin
                case (pc)
                    6'd0:  r = f_ldr(R_Z);
                    6'd1:  r = f_subk(32'sd11744051);
                    6'd2:  r = f_sat(R_T1);
                    6'd3:  r = f_ldk(32'sd0);
                    6'd4:  r = f_maccr(R_T1, R_X);
                    6'd5:  r = f_msubk(R_Y, 32'sd58720256);
                    6'd6:  r = f_sat(R_DX);
                    6'd7:  r = f_ldk(32'sd0);
                    6'd8:  r = f_macck(R_X, 32'sd58720256);
                    6'd9:  r = f_maccr(R_T1, R_Y);
                    6'd10: r = f_sat(R_DY);
                    6'd11: r = f_mulr(R_T0, R_Z, R_Z);
                    6'd12: r = f_mulr(R_T0, R_T0, R_Z);
                    6'd13: r = f_mulk(R_T0, R_T0, 32'sd5592405);
                    6'd14: r = f_ldk(32'sd0);
                    6'd15: r = f_maccr(R_X, R_X);
                    6'd16: r = f_maccr(R_Y, R_Y);
                    6'd17: r = f_sat(R_T1);
                    6'd18: r = f_ldk(ONE);
                    6'd19: r = f_macck(R_Z, 32'sd4194304);
                    6'd20: r = f_sat(R_DZ);
                    6'd21: r = f_mulr(R_T1, R_T1, R_DZ);
                    6'd22: r = f_mulk(R_DZ, R_Z, 32'sd1677722);
                    6'd23: r = f_mulr(R_DZ, R_DZ, R_X);
                    6'd24: r = f_mulr(R_DZ, R_DZ, R_X);
                    6'd25: r = f_mulr(R_DZ, R_DZ, R_X);
                    6'd26: r = f_ldk(32'sd10066330);
                    6'd27: r = f_macck(R_Z, 32'sd15938355);
                    6'd28: r = f_subr(R_T0);
                    6'd29: r = f_subr(R_T1);
                    6'd30: r = f_addr(R_DZ);
                    6'd31: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_FOURWING: begin
                case (pc)
                    6'd0:  r = f_mulk(R_T0, R_Y, 32'sd100663296);
                    6'd1:  r = f_ldk(32'sd0);
                    6'd2:  r = f_macck(R_X, 32'sd67108864);
                    6'd3:  r = f_msubr(R_T0, R_Z);
                    6'd4:  r = f_sat(R_DX);
                    6'd5:  r = f_ldk(32'sd0);
                    6'd6:  r = f_msubk(R_Y, 32'sd167772160);
                    6'd7:  r = f_maccr(R_X, R_Z);
                    6'd8:  r = f_sat(R_DY);
                    6'd9:  r = f_ldr(R_X);
                    6'd10: r = f_msubk(R_Z, 32'sd83886080);
                    6'd11: r = f_maccr(R_X, R_Y);
                    6'd12: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_DADRAS: begin
                case (pc)
                    6'd0:  r = f_mulk(R_T0, R_Y, 32'sd45298483);
                    6'd1:  r = f_ldr(R_Y);
                    6'd2:  r = f_msubk(R_X, 32'sd50331648);
                    6'd3:  r = f_maccr(R_T0, R_Z);
                    6'd4:  r = f_sat(R_DX);
                    6'd5:  r = f_ldr(R_Z);
                    6'd6:  r = f_macck(R_Y, 32'sd28521267);
                    6'd7:  r = f_msubr(R_X, R_Z);
                    6'd8:  r = f_sat(R_DY);
                    6'd9:  r = f_mulk(R_T0, R_X, 32'sd33554432);
                    6'd10: r = f_ldk(32'sd0);
                    6'd11: r = f_maccr(R_T0, R_Y);
                    6'd12: r = f_msubk(R_Z, 32'sd150994944);
                    6'd13: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_ZHOU: begin
                case (pc)
                    6'd0:  r = f_ldk(32'sd0);
                    6'd1:  r = f_macck(R_X, 32'sd49828332);
                    6'd2:  r = f_macck(R_Y, 32'sd2516582);
                    6'd3:  r = f_maccr(R_Y, R_Z);
                    6'd4:  r = f_sat(R_DX);
                    6'd5:  r = f_mulk(R_T0, R_Y, ONE);
                    6'd6:  r = f_ldk(32'sd0);
                    6'd7:  r = f_macck(R_Y, -32'sd50331648);
                    6'd8:  r = f_msubr(R_X, R_Z);
                    6'd9:  r = f_maccr(R_T0, R_Z);
                    6'd10: r = f_sat(R_DY);
                    6'd11: r = f_ldk(32'sd0);
                    6'd12: r = f_macck(R_Z, -32'sd147303956);
                    6'd13: r = f_msubr(R_X, R_Y);
                    6'd14: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_THOMAS: begin
                if (pc < 6'd7) begin
                    r = f_thomas(pc[2:0], R_X, R_Y, R_DX);
                end else if (pc < 6'd14) begin
                    r = f_thomas(3'(pc - 6'd7), R_Y, R_Z, R_DY);
                end else if (pc < 6'd21) begin
                    r = f_thomas(3'(pc - 6'd14), R_Z, R_X, R_DZ);
                end
            end
            SYS_RAYLEIGH: begin
                case (pc)
                    6'd0:  r = f_ldk(32'sd0);
                    6'd1:  r = f_msubk(R_X, 32'sd150994944);
                    6'd2:  r = f_macck(R_Y, 32'sd150994944);
                    6'd3:  r = f_sat(R_DX);
                    6'd4:  r = f_ldk(32'sd0);
                    6'd5:  r = f_macck(R_X, 32'sd201326592);
                    6'd6:  r = f_subr(R_Y);
                    6'd7:  r = f_msubr(R_X, R_Z);
                    6'd8:  r = f_sat(R_DY);
                    6'd9:  r = f_ldk(32'sd0);
                    6'd10: r = f_maccr(R_X, R_Y);
                    6'd11: r = f_msubk(R_Z, 32'sd83886080);
                    6'd12: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_CELL: begin
                case (pc)
                    6'd0:  r = f_clmp(R_T0, R_X);
                    6'd1:  r = f_clmp(R_T1, R_Y);
                    6'd2:  r = f_clmp(R_DZ, R_Z);
                    6'd3:  r = f_ldk(32'sd0);
                    6'd4:  r = f_subr(R_X);
                    6'd5:  r = f_macck(R_T0, 32'sd20803748);
                    6'd6:  r = f_msubk(R_T1, 32'sd53854863);
                    6'd7:  r = f_msubk(R_DZ, 32'sd53854863);
                    6'd8:  r = f_sat(R_DX);
                    6'd9:  r = f_ldk(32'sd0);
                    6'd10: r = f_subr(R_Y);
                    6'd11: r = f_msubk(R_T0, 32'sd53854863);
                    6'd12: r = f_macck(R_T1, 32'sd18454938);
                    6'd13: r = f_msubk(R_DZ, 32'sd73819750);
                    6'd14: r = f_sat(R_DY);
                    6'd15: r = f_ldk(32'sd0);
                    6'd16: r = f_subr(R_Z);
                    6'd17: r = f_msubk(R_T0, 32'sd53854863);
                    6'd18: r = f_macck(R_T1, 32'sd73819750);
                    6'd19: r = f_addr(R_DZ);
                    6'd20: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_BOUALI: begin
                case (pc)
                    6'd0:  r = f_ldk(32'sd67108864);
                    6'd1:  r = f_subr(R_Y);
                    6'd2:  r = f_sat(R_T0);
                    6'd3:  r = f_ldk(32'sd0);
                    6'd4:  r = f_maccr(R_X, R_T0);
                    6'd5:  r = f_macck(R_Z, 32'sd5033165);
                    6'd6:  r = f_sat(R_DX);
                    6'd7:  r = f_ldk(ONE);
                    6'd8:  r = f_msubr(R_X, R_X);
                    6'd9:  r = f_sat(R_T0);
                    6'd10: r = f_ldk(32'sd0);
                    6'd11: r = f_msubr(R_Y, R_T0);
                    6'd12: r = f_sat(R_DY);
                    6'd13: r = f_ldk(32'sd25165824);
                    6'd14: r = f_msubk(R_Z, ONE);
                    6'd15: r = f_sat(R_T0);
                    6'd16: r = f_ldk(32'sd0);
                    6'd17: r = f_msubr(R_X, R_T0);
                    6'd18: r = f_msubk(R_Z, 32'sd838861);
                    6'd19: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_CHENLEE: begin
                case (pc)
                    6'd0:  r = f_ldk(32'sd0);
                    6'd1:  r = f_macck(R_X, 32'sd83886080);
                    6'd2:  r = f_msubr(R_Y, R_Z);
                    6'd3:  r = f_sat(R_DX);
                    6'd4:  r = f_ldk(32'sd0);
                    6'd5:  r = f_macck(R_Y, -32'sd167772160);
                    6'd6:  r = f_maccr(R_X, R_Z);
                    6'd7:  r = f_sat(R_DY);
                    6'd8:  r = f_mulr(R_T0, R_X, R_Y);
                    6'd9:  r = f_ldk(32'sd0);
                    6'd10: r = f_macck(R_Z, -32'sd6375342);
                    6'd11: r = f_macck(R_T0, 32'sd5592405);
                    6'd12: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            SYS_ROESSLER: begin
                case (pc)
                    6'd0:  r = f_ldk(32'sd0);
                    6'd1:  r = f_subr(R_Y);
                    6'd2:  r = f_subr(R_Z);
                    6'd3:  r = f_sat(R_DX);
                    6'd4:  r = f_ldr(R_X);
                    6'd5:  r = f_macck(R_Y, 32'sd3355443);
                    6'd6:  r = f_sat(R_DY);
                    6'd7:  r = f_ldr(R_X);
                    6'd8:  r = f_subk(32'sd95630131);
                    6'd9:  r = f_sat(R_T0);
                    6'd10: r = f_ldk(32'sd3355443);
                    6'd11: r = f_maccr(R_Z, R_T0);
                    6'd12: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
            default: begin
                // Lorenz, also used for unassigned selector values.
                case (pc)
                    6'd0:  r = f_ldr(R_Y);
                    6'd1:  r = f_subr(R_X);
                    6'd2:  r = f_sat(R_T0);
                    6'd3:  r = f_mulk(R_DX, R_T0, 32'sd167772160);
                    6'd4:  r = f_ldk(32'sd469762048);
                    6'd5:  r = f_subr(R_Z);
                    6'd6:  r = f_sat(R_T0);
                    6'd7:  r = f_ldk(32'sd0);
                    6'd8:  r = f_maccr(R_X, R_T0);
                    6'd9:  r = f_subr(R_Y);
                    6'd10: r = f_sat(R_DY);
                    6'd11: r = f_ldk(32'sd0);
                    6'd12: r = f_maccr(R_X, R_Y);
                    6'd13: r = f_msubk(R_Z, 32'sd44739243);
                    6'd14: r = f_sat(R_DZ);
                    default: r = f_end();
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/core/chaotic_attractor_euler_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chaotic_attractor_euler_step
// One forward Euler step of a selectable chaotic system on a Q8.24 particle
// position, with a running peak of the output magnitudes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_ready       i_x_in, i_y_in, i_z_in, i_clear_peak
// output    out        o_valid / i_ready       o_x_out, o_y_out, o_z_out, o_peak_abs
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_system_select
//
// Each micro-instruction passes register file read, multiply and write-back
// through the one shared multiplier and accumulator, and the next one is
// issued only after that write-back.
// Reset is synchronous and active low; it selects Lorenz and clears the peak.
// A finished result waits in the output register while the next transaction
// is accepted and computed; the engine stalls only when that next result is done.
// ----------------------------------------------------------------------------
module chaotic_attractor_euler_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_in,
    input  logic signed [31:0] i_y_in,
    input  logic signed [31:0] i_z_in,
    input  logic               i_clear_peak,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_x_out,
    output logic signed [31:0] o_y_out,
    output logic signed [31:0] o_z_out,
    output logic [31:0]        o_peak_abs,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_system_select
);

    logic [3:0]         r_sys;
    logic               r_o_valid;
    logic               w_out_free;
    logic               w_load;
    logic               w_out_load;
    cae_pkg::t_cmd      w_cmd;
    logic signed [31:0] w_x_res;
    logic signed [31:0] w_y_res;
    logic signed [31:0] w_z_res;
    logic [31:0]        w_peak;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_o_valid || i_ready;
    assign o_valid     = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys <= cae_pkg::SYS_LORENZ;
        end else if (i_cfg_valid) begin
            r_sys <= i_cfg_system_select;
        end
    end

    cae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sys      (r_sys),
        .i_out_free (w_out_free),
        .o_in_ready (o_ready),
        .o_load     (w_load),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    cae_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_x_in       (i_x_in),
        .i_y_in       (i_y_in),
        .i_z_in       (i_z_in),
        .i_clear_peak (i_clear_peak),
        .i_cmd        (w_cmd),
        .o_x_res      (w_x_res),
        .o_y_res      (w_y_res),
        .o_z_res      (w_z_res),
        .o_peak       (w_peak)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (w_out_load) begin
            o_x_out    <= w_x_res;
            o_y_out    <= w_y_res;
            o_z_out    <= w_z_res;
            o_peak_abs <= w_peak;
        end
    end

endmodule

[rtl/core/cae_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/core/cae_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_dp
// Datapath: register file, shared multiplier, accumulator, sine table and
// running peak tracker. Runs each micro-instruction through fetch and execute.
// ----------------------------------------------------------------------------
module cae_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic signed [31:0]  i_x_in,
    input  logic signed [31:0]  i_y_in,
    input  logic signed [31:0]  i_z_in,
    input  logic                i_clear_peak,
    input  cae_pkg::t_cmd       i_cmd,
    output logic signed [31:0]  o_x_res,
    output logic signed [31:0]  o_y_res,
    output logic signed [31:0]  o_z_res,
    output logic [31:0]         o_peak
);

    logic signed [31:0] r_in [3];
    logic signed [31:0] r_res [3];
    logic [31:0]        r_peak;
    logic signed [39:0] r_acc;

    // Operand fetch stage (aligned with the RAM read data).
    logic               r_s1_vld;
    cae_pkg::t_instr    r_s1_ins;
    logic [31:0]        w_rd_a;
    logic [31:0]        w_rd_b;

    // Execute stage.
    logic               r_s2_vld;
    logic [4:0]         r_s2_op;
    logic [2:0]         r_s2_dst;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_prod;

    logic signed [31:0] w_opa;
    logic signed [31:0] w_opb;

    logic               w_we;
    logic signed [31:0] w_wdata;
    logic signed [31:0] w_mulsat;
    logic signed [31:0] w_accsat;
    logic signed [31:0] w_rom0;
    logic signed [31:0] w_rom1;
    logic [31:0]        w_abs;

    cae_ram #(
        .WIDTH (cae_pkg::DATA_W),
        .DEPTH (cae_pkg::RF_DEPTH)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_s2_dst),
        .i_wdata   (w_wdata),
        .i_raddr_a (i_cmd.instr.sa),
        .i_raddr_b (i_cmd.instr.sb),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_comb begin
        if (r_s1_ins.op == cae_pkg::OP_LDIN) begin
            w_opa = r_in[r_s1_ins.sa[1:0]];
        end else begin
            w_opa = $signed(w_rd_a);
        end
        if (r_s1_ins.bk) begin
            w_opb = r_s1_ins.k;
        end else if (r_s1_ins.op == cae_pkg::OP_FRC) begin
            // The interpolation weight is bits 23:8 of the turn phase.
            w_opb = $signed({16'b0, w_rd_b[23:8]});
        end else begin
            w_opb = $signed(w_rd_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_ins <= i_cmd.instr;
        r_s2_op  <= r_s1_ins.op;
        r_s2_dst <= r_s1_ins.dst;
        r_a      <= w_opa;
        r_b      <= w_opb;
        r_prod   <= w_opa * w_opb;
    end

    assign w_mulsat = cae_pkg::f_sat40(r_prod[63:24]);
    assign w_accsat = cae_pkg::f_sat40(r_acc);
    assign w_rom0   = cae_pkg::f_sine_rom(r_a[31:24]);
    assign w_rom1   = cae_pkg::f_sine_rom(r_a[31:24] + 8'd1);
    assign w_abs    = w_accsat[31] ? (~w_accsat + 32'd1) : w_accsat;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_accsat;
        if (r_s2_vld) begin
            case (r_s2_op)
                cae_pkg::OP_MUL: begin
                    w_we    = 1'b1;
                    w_wdata = w_mulsat;
                end
                cae_pkg::OP_PHS: begin
                    w_we    = 1'b1;
                    w_wdata = r_prod[47:16];
                end
                cae_pkg::OP_ROMD: begin
                    w_we    = 1'b1;
                    w_wdata = w_rom1 - w_rom0;
                end
                cae_pkg::OP_SAT, cae_pkg::OP_SATO: begin
                    w_we    = 1'b1;
                    w_wdata = w_accsat;
                end
                cae_pkg::OP_CLMP: begin
                    w_we = 1'b1;
                    if (r_a > cae_pkg::ONE) begin
                        w_wdata = cae_pkg::ONE;
                    end else if (r_a < -cae_pkg::ONE) begin
                        w_wdata = -cae_pkg::ONE;
                    end else begin
                        w_wdata = r_a;
                    end
                end
                cae_pkg::OP_LDIN: begin
                    w_we    = 1'b1;
                    w_wdata = r_a;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            case (r_s2_op)
                cae_pkg::OP_MACC: r_acc <= r_acc + 40'(w_mulsat);
                cae_pkg::OP_MSUB: r_acc <= r_acc - 40'(w_mulsat);
                cae_pkg::OP_FRC:  r_acc <= r_acc + r_prod[55:16];
                cae_pkg::OP_AROM: r_acc <= r_acc + 40'(w_rom0);
                cae_pkg::OP_LDA:  r_acc <= 40'(r_b);
                cae_pkg::OP_ADDA: r_acc <= r_acc + 40'(r_b);
                cae_pkg::OP_SUBA: r_acc <= r_acc - 40'(r_b);
                default:          r_acc <= r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in[0] <= i_x_in;
            r_in[1] <= i_y_in;
            r_in[2] <= i_z_in;
        end
        if (r_s2_vld && r_s2_op == cae_pkg::OP_SATO) begin
            r_res[r_s2_dst[1:0]] <= w_accsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (i_load && i_clear_peak) begin
            r_peak <= '0;
        end else if (r_s2_vld && r_s2_op == cae_pkg::OP_SATO && w_abs > r_peak) begin
            r_peak <= w_abs;
        end
    end

    assign o_x_res = r_res[0];
    assign o_y_res = r_res[1];
    assign o_z_res = r_res[2];
    assign o_peak  = r_peak;

endmodule

[rtl/core/cae_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_ctrl
// Sequencer: steps through the load, derivative and update microprograms of
// the selected system and hands each micro-instruction to the datapath.
// ----------------------------------------------------------------------------
module cae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [3:0]    i_sys,
    input  logic          i_out_free,
    output logic          o_in_ready,
    output logic          o_load,
    output logic          o_out_load,
    output cae_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEAD = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [5:0] r_pc, n_pc;
    logic [1:0] r_ph, n_ph;
    cae_pkg::t_instr w_ins;

    always_comb begin
        unique case (r_state)
            ST_HEAD: w_ins = cae_pkg::f_head(r_pc);
            ST_RUN:  w_ins = cae_pkg::f_prog(i_sys, r_pc);
            ST_TAIL: w_ins = cae_pkg::f_tail(i_sys, r_pc);
            default: w_ins = cae_pkg::f_end();
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_load     = o_in_ready && i_in_valid;

    always_comb begin
        n_state          = r_state;
        n_pc             = r_pc;
        n_ph             = r_ph;
        o_out_load       = 1'b0;
        o_cmd.issue      = 1'b0;
        o_cmd.instr      = w_ins;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_HEAD;
                    n_pc    = '0;
                    n_ph    = '0;
                end
            end
            ST_HEAD, ST_RUN, ST_TAIL: begin
                if (r_ph == 2'd0) begin
                    if (w_ins.op == cae_pkg::OP_END) begin
                        n_pc = '0;
                        n_state = (r_state == ST_HEAD) ? ST_RUN :
                                  (r_state == ST_RUN)  ? ST_TAIL : ST_FIN;
                    end else begin
                        o_cmd.issue = 1'b1;
                        n_ph        = 2'd1;
                    end
                end else if (r_ph == 2'd1) begin
                    n_ph = 2'd2;
                end else begin
                    // Write-back completes this cycle; the next fetch sees it.
                    n_ph = 2'd0;
                    n_pc = r_pc + 6'd1;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_ph    <= n_ph;
        end
    end

endmodule

[bench/cae_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cae_scoreboard
// Watches the input, output and configuration channels of the Euler step
// engine, predicts every next position and running peak, and compares each
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cae_scoreboard
    import cae_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic               i_clear,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_x_out,
    input  logic signed [31:0] i_y_out,
    input  logic signed [31:0] i_z_out,
    input  logic [31:0]        i_peak_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [3:0]         i_cfg_sel,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        peak;
    } t_point;

    t_point      next_pos_q[$];
    logic [3:0]  system_sel;
    logic [31:0] peak_mag;
    longint      quarter_wave[0:64];

    initial begin
        longint unsigned a, a2, term, s;
        longint unsigned divs[6];
        divs = '{156, 110, 72, 42, 20, 6};
        for (int r = 0; r <= 64; r++) begin
            a    = (64'd3373259426 * r) / 128;
            a2   = (a * a) >> 30;
            term = 64'd1 << 30;
            for (int i = 0; i < 6; i++) begin
                term = (64'd1 << 30) - ((a2 * term) >> 30) / divs[i];
            end
            s = (((a * term) >> 30) + 32) >> 6;
            if (s > 64'd16777216) begin
                s = 64'd16777216;
            end
            quarter_wave[r] = longint'(s);
        end
    end

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // Q8.24 product, floored, saturated.
    function automatic int qmul(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip32(p >>> 24);
    endfunction

    function automatic int clamp_unit(input int v);
        if (v > 16777216) begin
            return 16777216;
        end else if (v < -16777216) begin
            return -16777216;
        end
        return v;
    endfunction

    function automatic longint sine_entry(input logic [7:0] k);
        longint v;
        v = k[6] ? quarter_wave[64 - k[5:0]] : quarter_wave[k[5:0]];
        return k[7] ? -v : v;
    endfunction

    function automatic int table_sine(input int angle);
        longint      prod;
        logic [31:0] phase;
        longint      t0, t1, frac;
        prod  = (longint'(angle) * 64'sd2670177) >>> 16;
        phase = prod[31:0];
        frac  = longint'(phase[23:8]);
        t0    = sine_entry(phase[31:24]);
        t1    = sine_entry(phase[31:24] + 8'd1);
        return int'(t0 + (((t1 - t0) * frac) >>> 16));
    endfunction

    function automatic int euler(input int p, input int dt, input longint d);
        return clip32(longint'(p) + qmul(dt, clip32(d)));
    endfunction

    function automatic t_point euler_step(input logic [3:0] sys, input int x, input int y,
                                          input int z);
        t_point r;
        longint dx, dy, dz;
        int dt, zb, h1, h2, h3;
        case (sys)
            SYS_HALVOR: begin
                dt = 83886;
                dx = -longint'(qmul(23488102, x)) - qmul(67108864, y) - qmul(67108864, z)
                     - qmul(y, y);
                dy = -longint'(qmul(23488102, y)) - qmul(67108864, z) - qmul(67108864, x)
                     - qmul(z, z);
                dz = -longint'(qmul(23488102, z)) - qmul(67108864, x) - qmul(67108864, y)
                     - qmul(x, x);
            end
            SYS_AIZAWA: begin
                zb = clip32(longint'(z) - 11744051);
                dt = 167772;
                dx = longint'(qmul(zb, x)) - qmul(58720256, y);
                dy = longint'(qmul(58720256, x)) + qmul(zb, y);
                dz = 64'sd10066330 + qmul(15938355, z)
                     - qmul(qmul(qmul(z, z), z), 5592405)
                     - qmul(clip32(longint'(qmul(x, x)) + qmul(y, y)),
                            clip32(64'sd16777216 + qmul(4194304, z)))
                     + qmul(qmul(qmul(qmul(1677722, z), x), x), x);
            end
            SYS_FOURWING: begin
                dt = 83886;
                dx = longint'(qmul(67108864, x)) - qmul(qmul(100663296, y), z);
                dy = -longint'(qmul(167772160, y)) + qmul(x, z);
                dz = longint'(x) - qmul(83886080, z) + qmul(x, y);
            end
            SYS_DADRAS: begin
                dt = 167772;
                dx = longint'(y) - qmul(50331648, x) + qmul(qmul(45298483, y), z);
                dy = longint'(qmul(28521267, y)) - qmul(x, z) + z;
                dz = longint'(qmul(qmul(33554432, x), y)) - qmul(150994944, z);
            end
            SYS_ZHOU: begin
                dt = 33554;
                dx = longint'(qmul(49828332, x)) + qmul(2516582, y) + qmul(y, z);
                dy = longint'(qmul(-50331648, y)) - qmul(x, z) + qmul(qmul(16777216, y), z);
                dz = longint'(qmul(-147303956, z)) - qmul(x, y);
            end
            SYS_THOMAS: begin
                dt = 1677722;
                dx = -longint'(qmul(3187671, x)) + table_sine(y);
                dy = -longint'(qmul(3187671, y)) + table_sine(z);
                dz = -longint'(qmul(3187671, z)) + table_sine(x);
            end
            SYS_RAYLEIGH: begin
                dt = 838861;
                dx = -longint'(qmul(150994944, x)) + qmul(150994944, y);
                dy = longint'(qmul(201326592, x)) - y - qmul(x, z);
                dz = longint'(qmul(x, y)) - qmul(83886080, z);
            end
            SYS_CELL: begin
                h1 = clamp_unit(x);
                h2 = clamp_unit(y);
                h3 = clamp_unit(z);
                dt = 117441;
                dx = -longint'(x) + qmul(20803748, h1) - qmul(53854863, h2)
                     - qmul(53854863, h3);
                dy = -longint'(y) - qmul(53854863, h1) + qmul(18454938, h2)
                     - qmul(73819750, h3);
                dz = -longint'(z) - qmul(53854863, h1) + qmul(73819750, h2) + h3;
            end
            SYS_BOUALI: begin
                dt = 100663;
                dx = longint'(qmul(x, clip32(64'sd67108864 - y))) + qmul(5033165, z);
                dy = -longint'(qmul(y, clip32(64'sd16777216 - qmul(x, x))));
                dz = -longint'(qmul(x, clip32(64'sd25165824 - qmul(16777216, z))))
                     - qmul(838861, z);
            end
            SYS_CHENLEE: begin
                dt = 67109;
                dx = longint'(qmul(83886080, x)) - qmul(y, z);
                dy = longint'(qmul(-167772160, y)) + qmul(x, z);
                dz = longint'(qmul(-6375342, z)) + qmul(qmul(x, y), 5592405);
            end
            SYS_ROESSLER: begin
                dt = 838861;
                dx = -longint'(y) - z;
                dy = longint'(x) + qmul(3355443, y);
                dz = 64'sd3355443 + qmul(z, clip32(longint'(x) - 95630131));
            end
            default: begin
                dt = 167772;
                dx = qmul(167772160, clip32(longint'(y) - x));
                dy = longint'(qmul(x, clip32(64'sd469762048 - z))) - y;
                dz = longint'(qmul(x, y)) - qmul(44739243, z);
            end
        endcase
        r.x = euler(x, dt, dx);
        r.y = euler(y, dt, dy);
        r.z = euler(z, dt, dz);
        r.peak = '0;
        return r;
    endfunction

    function automatic logic [31:0] magnitude(input logic signed [31:0] v);
        longint m;
        m = (v < 0) ? -longint'(v) : longint'(v);
        return m[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            system_sel = SYS_LORENZ;
            peak_mag   = '0;
            next_pos_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (next_pos_q.size() == 0) begin
                    $display("%0t ns: result transaction with nothing expected", $time);
                    o_errors++;
                end else begin
                    want = next_pos_q.pop_front();
                    if (i_x_out !== want.x) report_mismatch("x_out", i_x_out, want.x);
                    if (i_y_out !== want.y) report_mismatch("y_out", i_y_out, want.y);
                    if (i_z_out !== want.z) report_mismatch("z_out", i_z_out, want.z);
                    if (i_peak_out !== want.peak) begin
                        report_mismatch("peak_abs", i_peak_out, want.peak);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                system_sel = i_cfg_sel;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_clear) begin
                    peak_mag = '0;
                end
                want = euler_step(system_sel, i_x, i_y, i_z);
                if (magnitude(want.x) > peak_mag) peak_mag = magnitude(want.x);
                if (magnitude(want.y) > peak_mag) peak_mag = magnitude(want.y);
                if (magnitude(want.z) > peak_mag) peak_mag = magnitude(want.z);
                want.peak = peak_mag;
                next_pos_q.push_back(want);
            end
        end
        o_pending = next_pos_q.size();
    end

endmodule

[bench/tb_chaotic_attractor_euler_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chaotic_attractor_euler_step
// Drives positions through the Euler step engine under every system
// selection, with random gaps on the input side and random stalls on the
// output side; the scoreboard beside the engine checks every result.
// ----------------------------------------------------------------------------
module tb_chaotic_attractor_euler_step;
    import cae_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_x_in;
    logic signed [31:0] i_y_in;
    logic signed [31:0] i_z_in;
    logic               i_clear_peak;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;
    logic signed [31:0] o_z_out;
    logic [31:0]        o_peak_abs;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_system_select;
    int                 mismatch_count;
    int                 results_pending;
    bit                 quiet_sender;

    chaotic_attractor_euler_step DUT (.*);

    cae_scoreboard u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_x         (i_x_in),
        .i_y         (i_y_in),
        .i_z         (i_z_in),
        .i_clear     (i_clear_peak),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_x_out     (o_x_out),
        .i_y_out     (o_y_out),
        .i_z_out     (o_z_out),
        .i_peak_out  (o_peak_abs),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_sel   (i_cfg_system_select),
        .o_errors    (mismatch_count),
        .o_pending   (results_pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic signed [31:0] coord();
        case ($urandom_range(0, 11))
            0:       return $urandom;
            1:       return 32'sh7fffffff;
            2:       return 32'sh80000000;
            3:       return $signed($urandom) >>> $urandom_range(0, 3);
            default: return $signed($urandom) >>> $urandom_range(3, 9);
        endcase
    endfunction

    // Output side: stretches of steady readiness alternate with stalls.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(100, 600)) @(posedge i_clk);
            end else begin
                i_ready <= (idle_len() == 0);
            end
        end
    end

    task automatic send_position(input logic signed [31:0] x, input logic signed [31:0] y,
                                 input logic signed [31:0] z, input logic clr);
        int gap;
        i_valid      <= 1'b1;
        i_x_in       <= x;
        i_y_in       <= y;
        i_z_in       <= z;
        i_clear_peak <= clr;
        do @(posedge i_clk); while (!o_ready);
        gap = quiet_sender ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    task automatic select_system(input logic [3:0] sel);
        drain_results();
        i_cfg_valid         <= 1'b1;
        i_cfg_system_select <= sel;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [3:0] sel;
        int         n;
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_x_in              <= '0;
        i_y_in              <= '0;
        i_z_in              <= '0;
        i_clear_peak        <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_system_select <= '0;
        quiet_sender         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners under the reset selection (Lorenz).
        send_position(0, 0, 0, 1'b0);
        send_position(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_position(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
        send_position(32'sh80000000, 32'sh7fffffff, 0, 1'b1);
        send_position(-1, 1, -1, 1'b1);
        send_position(32'sh01000000, 32'sh01000000, 32'sh01000000, 1'b1);

        // Systems 1 to 12 with a typical and an extreme point, 0 and 15 typical only.
        for (int s = 0; s < 16; s++) begin
            if (s > 0 && s < 13 || s == 0 || s == 15) begin
                select_system(4'(s));
                send_position(32'sh01800000, -32'sh00c00000, 32'sh02000000, 1'b1);
                if (s > 0 && s < 13) begin
                    send_position(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
                end
            end
        end

        // Random phases, each under one selection, extremes included.
        for (int phase = 0; phase < 24; phase++) begin
            case (phase)
                0:       sel = 4'd0;
                1:       sel = 4'd15;
                2:       sel = SYS_ROESSLER;
                3:       sel = SYS_LORENZ;
                default: sel = 4'($urandom_range(0, 15));
            endcase
            select_system(sel);
            quiet_sender = (phase % 6 == 5);
            n = 80;
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && phase == 7) begin
                    drain_results();
                end
                send_position(coord(), coord(), coord(), $urandom_range(0, 15) == 0);
            end
        end
        quiet_sender = 1'b0;

        drain_results();
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[chaotic_attractor_euler_step.f]
rtl/core/cae_pkg.sv
rtl/core/cae_ram.sv
rtl/core/cae_dp.sv
rtl/core/cae_ctrl.sv
rtl/core/chaotic_attractor_euler_step.sv
bench/cae_scoreboard.sv
bench/tb_chaotic_attractor_euler_step.sv
